@@ src/lpcr_pkg.sv @@
// Shared types, constants and helpers for the LPC residual FIR filter.
// No dependencies; compiled first.
package lpcr_pkg;

  localparam int MAX_TAPS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS      = 24;
  localparam int COEFF_FRAC      = 20;
  localparam int ORDER_W         = 8;
  localparam int SLOT_W          = 8;
  localparam int ORDER_LIMIT     = 199;
  localparam int ORDER_RESET     = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_EMIT
  } lpcr_state_t;

  // Order is forced into 1..lim
  function automatic logic [ORDER_W-1:0] clamp_order(logic [ORDER_W-1:0] v, int lim);
    int o;
    o = int'(v);
    if (o < 1) o = 1;
    if (o > lim) o = lim;
    return ORDER_W'(o);
  endfunction

endpackage

@@ src/lpcr_in_if.sv @@
// Input channel: one audio sample plus an optional coefficient write.
// Depends on lpcr_pkg.
interface lpcr_in_if #(
  parameter int SAMPLE_BITS = lpcr_pkg::SAMPLE_BITS_DEF
);
  import lpcr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [COEFF_BITS-1:0]  coeff_value;
  logic [SLOT_W-1:0]             coeff_slot;

  modport source (output valid, output sample_in, output coeff_value, output coeff_slot,
                  input ready);
  modport sink   (input valid, input sample_in, input coeff_value, input coeff_slot,
                  output ready);
endinterface

@@ src/lpcr_out_if.sv @@
// Result channel: one prediction error sample per transfer.
// Depends on lpcr_pkg.
interface lpcr_out_if #(
  parameter int SAMPLE_BITS = lpcr_pkg::SAMPLE_BITS_DEF
);
  import lpcr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] residual_out;

  modport source (output valid, output residual_out, input ready);
  modport sink   (input valid, input residual_out, output ready);
endinterface

@@ src/lpcr_cfg_if.sv @@
// Configuration write channel for the filter order register.
// Depends on lpcr_pkg.
interface lpcr_cfg_if;
  import lpcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ORDER_W-1:0] filter_order;

  modport source (output valid, output filter_order, input ready);
  modport sink   (input valid, input filter_order, output ready);
endinterface

@@ src/lpc_residual_fir_filter_unit.sv @@
// LPC prediction-error FIR filter, top level.
// Depends on lpcr_pkg, lpcr_in_if, lpcr_out_if and lpcr_cfg_if.
//
// Usage:
//   in_chan  : sample, coefficient value and slot. Slot k (nonzero) stages
//              coefficient k-1; slot equal to the order also copies the
//              staging bank to the active bank before this sample is filtered.
//   out_chan : one saturated residual per input transfer, in order.
//   cfg_chan : filter order (clamped to 1..199 and below MAX_TAPS). Always
//              ready; a write clears coefficients and history.
// Operation: each item is filtered by the single multiply-accumulate stepping
//   one tap per cycle through the history, active and staging memories, then
//   drained, rounded, saturated and loaded into the output register; a new
//   input is accepted only after the block has returned to idle.
// Reset and order writes start a clearing sweep over all MAX_TAPS entries that
//   zeroes all three memories; in_chan.ready stays low during it.
// The result sits in an output register; a new item is accepted while it
//   waits, and the block only holds in its final step if the previous
//   result has still not been taken by the receiver.
module lpc_residual_fir_filter_unit #(
  parameter int MAX_TAPS    = lpcr_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = lpcr_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lpcr_in_if.sink     in_chan,
  lpcr_out_if.source  out_chan,
  lpcr_cfg_if.sink    cfg_chan
);
  import lpcr_pkg::*;

  localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W   = (AW > ORDER_W) ? AW : ORDER_W;
  localparam int PW      = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W   = PW + AW;
  localparam int DW      = ACC_W + 2;
  localparam int RW      = DW - COEFF_FRAC;
  localparam int ORD_MAX = (ORDER_LIMIT < MAX_TAPS - 1) ? ORDER_LIMIT : MAX_TAPS - 1;

  localparam logic signed [RW-1:0] SAT_MAX =
    {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN =
    {{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Storage
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  act_mem  [MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  stg_mem  [MAX_TAPS];

  lpcr_state_t state_r, state_nxt;

  logic [ORDER_W-1:0]            ord_r;
  logic [AW-1:0]                 tap_r;
  logic [AW-1:0]                 clr_r;
  logic [AW-1:0]                 rd_addr_r;
  logic                          rd_v_r;
  logic                          prod_v_r;
  logic                          copy_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [COEFF_BITS-1:0]  act_q;
  logic signed [COEFF_BITS-1:0]  stg_q;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [RW-1:0]          res_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          clr_we;
  logic                          issue;
  logic                          emit_load;
  logic                          last_tap;
  logic                          clr_done;
  logic                          stage_ok;
  logic [SLOT_W-1:0]             slot_m1;
  logic [AW-1:0]                 stage_addr;
  logic signed [SAMPLE_BITS-1:0] hist_wdata;
  logic signed [COEFF_BITS-1:0]  coeff_sel;
  logic signed [DW-1:0]          diff_w;
  logic signed [SAMPLE_BITS-1:0] sat_w;

  // Handshakes
  assign in_chan.ready         = (state_r == ST_IDLE);
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.residual_out = out_data_r;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid;

  assign last_tap = (CNT_W'(tap_r) == CNT_W'(ord_r) - CNT_W'(1));
  assign clr_done = (clr_r == AW'(MAX_TAPS - 1));

  assign slot_m1    = in_chan.coeff_slot - SLOT_W'(1);
  assign stage_addr = AW'(slot_m1);
  assign stage_ok   = (in_chan.coeff_slot != '0) && (int'(slot_m1) < MAX_TAPS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_RUN;
      ST_RUN:    if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!rd_v_r && !prod_v_r) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_EMIT;
      ST_EMIT:   if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
    if (cfg_fire) state_nxt = ST_CLEAR;
  end

  // Control outputs of the sequencer
  always_comb begin
    clr_we    = 1'b0;
    issue     = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_RUN:   issue = 1'b1;
      ST_EMIT:  emit_load = !out_valid_r || out_chan.ready;
      default: begin
      end
    endcase
  end

  // History shifts by one as taps stream past: entry k takes the old entry k-1
  assign hist_wdata = (tap_r == '0) ? sample_r : hist_q;
  assign coeff_sel  = copy_r ? stg_q : act_q;

  assign diff_w = (DW'(sample_r) <<< COEFF_FRAC) - DW'(acc_r)
                + (DW'(1) <<< (COEFF_FRAC - 1));

  always_comb begin
    if (res_r > SAT_MAX) begin
      sat_w = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (res_r < SAT_MIN) begin
      sat_w = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      sat_w = res_r[SAMPLE_BITS-1:0];
    end
  end

  // Memories: read-first, registered read data
  always_ff @(posedge clk) begin
    if (clr_we) begin
      hist_mem[clr_r] <= '0;
    end else if (issue) begin
      hist_mem[tap_r] <= hist_wdata;
    end
    hist_q <= hist_mem[tap_r];
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      stg_mem[clr_r] <= '0;
    end else if (in_fire && stage_ok) begin
      stg_mem[stage_addr] <= in_chan.coeff_value;
    end
    stg_q <= stg_mem[tap_r];
  end

  // Bank copy rides along the filter pass, one tap behind the read
  always_ff @(posedge clk) begin
    if (clr_we) begin
      act_mem[clr_r] <= '0;
    end else if (rd_v_r && copy_r) begin
      act_mem[rd_addr_r] <= stg_q;
    end
    act_q <= act_mem[tap_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ord_r       <= clamp_order(ORDER_W'(ORDER_RESET), ORD_MAX);
      clr_r       <= '0;
      tap_r       <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        ord_r <= clamp_order(cfg_chan.filter_order, ORD_MAX);
      end
      if (cfg_fire) begin
        clr_r <= '0;
      end else if (clr_we) begin
        clr_r <= clr_r + AW'(1);
      end
      if (in_fire) begin
        tap_r <= '0;
      end else if (issue) begin
        tap_r <= tap_r + AW'(1);
      end
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_chan.sample_in;
      copy_r   <= (in_chan.coeff_slot == ord_r);
    end
    rd_addr_r <= tap_r;
    if (rd_v_r) begin
      prod_r <= hist_q * coeff_sel;
    end
    if (in_fire) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_FINISH) begin
      res_r <= RW'(diff_w >>> COEFF_FRAC);
    end
    if (emit_load) begin
      out_data_r <= sat_w;
    end
  end

endmodule

@@ verif/lpc_residual_fir_filter_unit_test.sv @@
// Self-checking bench for the LPC residual FIR filter: a queue-fed driver, a
// scoreboarding monitor and an in-bench filter predictor.
// Depends on lpcr_pkg, the three channel interfaces and the filter top level.
module lpc_residual_fir_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpcr_pkg::*;

  localparam int MAX_TAPS    = MAX_TAPS_DEF;
  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 500;
  localparam int RUN_LIMIT   = 2_000_000;
  localparam int BUSY_PCT    = 36;
  localparam int SLOW_PCT    = 84;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic signed [SB-1:0] SAMPLE_TOP    = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_BOTTOM = {1'b1, {(SB - 1){1'b0}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_TOP    = {1'b0, {(COEFF_BITS - 1){1'b1}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_BOTTOM = {1'b1, {(COEFF_BITS - 1){1'b0}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_UNITY  = COEFF_BITS'(1) <<< COEFF_FRAC;

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL_RATE
  } pace_t;

  typedef struct packed {
    logic signed [SB-1:0]         sample;
    logic signed [COEFF_BITS-1:0] coeff;
    logic [SLOT_W-1:0]            slot;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst_n;

  lpcr_in_if  #(.SAMPLE_BITS(SB)) in_chan ();
  lpcr_out_if #(.SAMPLE_BITS(SB)) out_chan ();
  lpcr_cfg_if                     cfg_chan ();

  lpc_residual_fir_filter_unit #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SB)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic signed [COEFF_BITS-1:0] coeff_active [MAX_TAPS];
  logic signed [COEFF_BITS-1:0] coeff_staged [MAX_TAPS];
  logic signed [SB-1:0]         past_samples [MAX_TAPS];
  int                           taps;

  sample_item_t         samples_to_send [$];
  logic signed [SB-1:0] residuals_due [$];
  sample_item_t         item_on_bus;

  pace_t pace = PACE_SLOW_SINK;
  int    fault_count = 0;
  int    items_queued = 0;
  int    cycle_count = 0;
  int    hold_left = 0;
  bit    hold_wanted = 1'b0;
  bit    hold_used = 1'b0;

  function automatic int order_after_write(logic [ORDER_W-1:0] raw);
    int o;
    o = int'(raw);
    if (o < 1) o = 1;
    if (o > ORDER_LIMIT) o = ORDER_LIMIT;
    if (o > MAX_TAPS - 1) o = MAX_TAPS - 1;
    return o;
  endfunction

  function automatic void clear_banks();
    for (int i = 0; i < MAX_TAPS; i++) begin
      coeff_active[i] = '0;
      coeff_staged[i] = '0;
      past_samples[i] = '0;
    end
  endfunction

  // Advances the predictor by one transfer and returns the residual it yields
  function automatic logic signed [SB-1:0] lpc_residual_of(sample_item_t it);
    longint acc;
    longint diff;
    acc = 0;
    if (it.slot != 0) begin
      if (int'(it.slot) - 1 < MAX_TAPS) coeff_staged[it.slot - SLOT_W'(1)] = it.coeff;
      // bank swap applies to this very sample
      if (int'(it.slot) == taps) begin
        for (int i = 0; i < taps; i++) coeff_active[i] = coeff_staged[i];
      end
    end
    for (int i = 0; i < taps; i++) begin
      acc += longint'(coeff_active[i]) * longint'(past_samples[i]);
    end
    diff = (longint'($signed(it.sample)) <<< COEFF_FRAC) - acc;
    diff = (diff + (64'sd1 <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    if (diff > SAMPLE_MAX) diff = SAMPLE_MAX;
    if (diff < SAMPLE_MIN) diff = SAMPLE_MIN;
    for (int i = taps - 1; i > 0; i--) past_samples[i] = past_samples[i - 1];
    past_samples[0] = it.sample;
    return diff[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    v = SB'($urandom);
    case ($urandom_range(7))
      0, 1, 2: return v;
      3, 4, 5: return v >>> $urandom_range(1, 10);
      6:       return $urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
      default: begin
        v = SB'(int'($urandom_range(2)) - 1);
        return v;
      end
    endcase
  endfunction

  // Mostly small taps so the residual is not pinned at the rails
  function automatic logic signed [COEFF_BITS-1:0] pick_coeff();
    logic signed [COEFF_BITS-1:0] c;
    c = COEFF_BITS'($urandom);
    case ($urandom_range(7))
      0, 1:    return c;
      7:       return $urandom_range(1) ? COEFF_TOP : COEFF_BOTTOM;
      default: return c >>> $urandom_range(3, 12);
    endcase
  endfunction

  task automatic queue_item(input logic signed [SB-1:0] sample,
                            input logic signed [COEFF_BITS-1:0] coeff,
                            input int slot);
    sample_item_t it;
    it.sample = sample;
    it.coeff  = coeff;
    it.slot   = SLOT_W'(slot);
    samples_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_chan.valid || residuals_due.size() != 0);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] raw);
    @(posedge clk);
    cfg_chan.valid        <= 1'b1;
    cfg_chan.filter_order <= raw;
    do @(posedge clk);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    taps = order_after_write(raw);
    clear_banks();
    @(negedge clk);
  endtask

  // Sender: one item held on the bus until its transfer, gaps only between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) residuals_due.push_back(lpc_residual_of(item_on_bus));
      if (!in_chan.valid || in_chan.ready) begin
        if (samples_to_send.size() != 0 &&
            $urandom_range(99) >= (pace == PACE_SLOW_SINK   ? BUSY_PCT :
                                   pace == PACE_SLOW_SOURCE ? SLOW_PCT : 0)) begin
          item_on_bus = samples_to_send.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.sample_in   <= item_on_bus.sample;
          in_chan.coeff_value <= item_on_bus.coeff;
          in_chan.coeff_slot  <= item_on_bus.slot;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, one shot
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_wanted && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver and scoreboard
  always @(posedge clk) begin
    logic signed [SB-1:0] want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (residuals_due.size() == 0) begin
          $error("residual_out: no result expected, got %0d", out_chan.residual_out);
          fault_count++;
        end else begin
          want = residuals_due.pop_front();
          if (out_chan.residual_out !== want) begin
            $error("residual_out: expected %0d, got %0d", want, out_chan.residual_out);
            fault_count++;
          end
        end
      end
      out_chan.ready <= (hold_left == 0) &&
                        ($urandom_range(99) >= (pace == PACE_SLOW_SINK   ? SLOW_PCT :
                                                pace == PACE_SLOW_SOURCE ? BUSY_PCT : 0));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int                 directed_items;
    int                 random_items;
    int                 phase;
    int                 budget;
    int                 phase_start;
    int                 pick;
    int                 upto;
    logic [ORDER_W-1:0] raw;

    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.sample_in     = '0;
    in_chan.coeff_value   = '0;
    in_chan.coeff_slot    = '0;
    out_chan.ready        = 1'b0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.filter_order = '0;
    taps = order_after_write(ORDER_W'(ORDER_RESET));
    clear_banks();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset order
    queue_item(SAMPLE_TOP, COEFF_TOP, 0);
    queue_item(SAMPLE_BOTTOM, COEFF_BOTTOM, 0);
    queue_item('0, COEFF_TOP, 1);
    queue_item(SB'(-1), COEFF_BOTTOM, 2);
    queue_item(SB'(12345), COEFF_UNITY, 9);
    queue_item(SAMPLE_TOP, COEFF_TOP, 11);        // staged above the order
    queue_item(SAMPLE_BOTTOM, COEFF_BOTTOM, 255); // top slot
    queue_item(SB'(-4096), -COEFF_UNITY, 10);     // swap on this sample
    for (int i = 0; i < 6; i++) queue_item(i[0] ? SAMPLE_BOTTOM : SAMPLE_TOP, '0, 0);
    queue_item('0, '0, 10);
    queue_item(SAMPLE_TOP, COEFF_BITS'(1), 3);
    queue_item(SB'(1), '0, 0);
    queue_item(SB'(-1), '0, 0);
    directed_items = items_queued;

    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      case (phase)
        0: raw = '0;
        1: raw = '1;
        2: raw = ORDER_W'(3);
        3: raw = ORDER_W'($urandom_range(200, 254));
        default: begin
          pick = $urandom_range(39);
          if (pick == 0)      raw = ORDER_W'($urandom_range(200, 255));
          else if (pick < 8)  raw = ORDER_W'($urandom_range(13, 48));
          else                raw = ORDER_W'($urandom_range(1, 12));
        end
      endcase
      write_order(raw);
      if (random_items < RANDOM_ITEMS / 3)          pace = PACE_SLOW_SINK;
      else if (random_items < 2 * RANDOM_ITEMS / 3) pace = PACE_SLOW_SOURCE;
      else                                          pace = PACE_FULL_RATE;
      // block fills up and stalls its input while the receiver holds off
      if (phase == 2) hold_wanted = 1'b1;
      budget = (taps > 48) ? taps + $urandom_range(10, 30) : $urandom_range(40, 140);
      phase_start = items_queued;
      while (items_queued - phase_start < budget) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          for (int k = 1; k <= taps; k++) queue_item(pick_sample(), pick_coeff(), k);
          repeat ($urandom_range(3, 30)) queue_item(pick_sample(), pick_coeff(), 0);
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 10))
            queue_item(pick_sample(), pick_coeff(), $urandom_range(255));
        end else begin
          // load cut short, no swap
          upto = $urandom_range(1, taps);
          for (int k = 1; k < upto; k++) queue_item(pick_sample(), pick_coeff(), k);
          repeat ($urandom_range(1, 8)) queue_item(pick_sample(), pick_coeff(), 0);
        end
      end
      random_items = items_queued - directed_items;
      phase++;
    end

    wait_drained();
    repeat (ORDER_LIMIT + 16) @(negedge clk);
    if (fault_count == 0 && residuals_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
